### hdl/lpfs_pkg.sv
// Shared types, constants and register map for the LED palette fade sequencer.
package lpfs_pkg;

  localparam int PALETTE_SIZE = 6;
  localparam int CHAN_W       = 8;
  localparam int STEP_W       = 9;
  localparam int TICK_W       = 16;
  localparam int IDX_W        = 3;
  localparam int COUNT_W      = 3;
  localparam int RGB_W        = 24;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int BITCNT_W     = $clog2(CHAN_W);

  localparam logic [COUNT_W-1:0] COLOR_COUNT_RESET = 3'd6;
  localparam logic [TICK_W-1:0]  STEPS_RESET       = 16'd64;

  localparam logic [RGB_W-1:0] PALETTE_RESET [PALETTE_SIZE] = '{
    24'h800040, 24'h404080, 24'h004080, 24'h008080, 24'h008040, 24'h400080
  };

  localparam logic [CHAN_W-1:0] INVERT_OFFSET = 8'h80;

  // fade starts from black toward entry 0
  localparam logic [STEP_W-1:0] RED_STEP_RESET   =
    STEP_W'(PALETTE_RESET[0][23:16] / STEPS_RESET);
  localparam logic [STEP_W-1:0] GREEN_STEP_RESET =
    STEP_W'(PALETTE_RESET[0][15:8] / STEPS_RESET);
  localparam logic [STEP_W-1:0] BLUE_STEP_RESET  =
    STEP_W'(PALETTE_RESET[0][7:0] / STEPS_RESET);

  // register indexes
  localparam logic [2:0] REG_COLOR_COUNT     = 3'd0;
  localparam logic [2:0] REG_STEPS_PER_COLOR = 3'd1;
  localparam logic [2:0] REG_PALETTE_0       = 3'd2;
  localparam logic [2:0] REG_PALETTE_5       = 3'd7;

  // channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_CUR,
    ST_RD_NXT,
    ST_LOAD,
    ST_DIVIDE,
    ST_STORE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       rd_en;
    logic       rd_next;
    logic       from_load;
    logic       div_load;
    logic       div_iter;
    logic       step_write;
    logic [1:0] chan;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic advance;
    logic out_free;
  } status_t;

endpackage

### hdl/lpfs_regs.sv
// Configuration registers and palette memory with APB-style access.
module lpfs_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lpfs_pkg::ADDR_W-1:0]         paddr,
  input  logic [lpfs_pkg::DATA_W-1:0]         pwdata,
  output logic [lpfs_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  output logic [lpfs_pkg::COUNT_W-1:0]        color_count,
  output logic [lpfs_pkg::TICK_W-1:0]         steps_per_color,
  input  logic                                rd_en,
  input  logic [lpfs_pkg::IDX_W-1:0]          rd_addr,
  output logic [lpfs_pkg::RGB_W-1:0]          rd_data
);

  logic [lpfs_pkg::RGB_W-1:0]        palette_mem [lpfs_pkg::PALETTE_SIZE];
  logic [lpfs_pkg::PALETTE_SIZE-1:0] palette_written;
  logic [2:0]                        reg_idx;
  logic [lpfs_pkg::IDX_W-1:0]        pal_idx;
  logic                              wr;
  logic                              setup_rd;
  logic                              is_pal;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[4:2];
  assign pal_idx  = reg_idx - lpfs_pkg::REG_PALETTE_0;
  assign is_pal   = (reg_idx >= lpfs_pkg::REG_PALETTE_0);
  assign wr       = psel & penable & pwrite & pready;
  assign setup_rd = psel & ~penable;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_count     <= lpfs_pkg::COLOR_COUNT_RESET;
      steps_per_color <= lpfs_pkg::STEPS_RESET;
      palette_written <= '0;
    end else if (wr) begin
      case (reg_idx) inside
        lpfs_pkg::REG_COLOR_COUNT:     color_count <= pwdata[lpfs_pkg::COUNT_W-1:0];
        lpfs_pkg::REG_STEPS_PER_COLOR: steps_per_color <= pwdata[lpfs_pkg::TICK_W-1:0];
        [lpfs_pkg::REG_PALETTE_0:lpfs_pkg::REG_PALETTE_5]: palette_written[pal_idx] <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr && is_pal) begin
      palette_mem[pal_idx] <= pwdata[lpfs_pkg::RGB_W-1:0];
    end
  end

  // unwritten entries read as their reset color
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= palette_written[rd_addr] ? palette_mem[rd_addr]
                                          : lpfs_pkg::PALETTE_RESET[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (setup_rd) begin
      case (reg_idx) inside
        lpfs_pkg::REG_COLOR_COUNT:     prdata <= lpfs_pkg::DATA_W'(color_count);
        lpfs_pkg::REG_STEPS_PER_COLOR: prdata <= lpfs_pkg::DATA_W'(steps_per_color);
        [lpfs_pkg::REG_PALETTE_0:lpfs_pkg::REG_PALETTE_5]: begin
          prdata <= lpfs_pkg::DATA_W'(palette_written[pal_idx] ? palette_mem[pal_idx]
                                       : lpfs_pkg::PALETTE_RESET[pal_idx]);
        end
        default: prdata <= '0;
      endcase
    end
  end

endmodule

### hdl/lpfs_ctrl.sv
// Sequencer state machine: accept, palette reads, per-channel divide, commit.
module lpfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick_valid,
  output logic              tick_stall,
  input  lpfs_pkg::status_t status,
  output lpfs_pkg::cmd_t    cmd
);

  lpfs_pkg::state_t                state, state_next;
  logic [1:0]                      chan, chan_next;
  logic [lpfs_pkg::BITCNT_W-1:0]   bit_cnt, bit_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lpfs_pkg::ST_IDLE;
      chan    <= lpfs_pkg::CH_RED;
      bit_cnt <= '0;
    end else begin
      state   <= state_next;
      chan    <= chan_next;
      bit_cnt <= bit_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    chan_next    = chan;
    bit_cnt_next = bit_cnt;
    cmd          = '0;
    cmd.chan     = chan;
    tick_stall   = 1'b1;
    case (state)
      lpfs_pkg::ST_IDLE: begin
        tick_stall = 1'b0;
        if (tick_valid) begin
          cmd.capture = 1'b1;
          state_next  = status.advance ? lpfs_pkg::ST_RD_CUR : lpfs_pkg::ST_FINISH;
        end
      end
      lpfs_pkg::ST_RD_CUR: begin
        cmd.rd_en  = 1'b1;
        state_next = lpfs_pkg::ST_RD_NXT;
      end
      lpfs_pkg::ST_RD_NXT: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_next   = 1'b1;
        cmd.from_load = 1'b1;
        state_next    = lpfs_pkg::ST_LOAD;
      end
      lpfs_pkg::ST_LOAD: begin
        cmd.div_load = 1'b1;
        bit_cnt_next = '0;
        state_next   = lpfs_pkg::ST_DIVIDE;
      end
      lpfs_pkg::ST_DIVIDE: begin
        cmd.div_iter = 1'b1;
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == lpfs_pkg::BITCNT_W'(lpfs_pkg::CHAN_W - 1)) begin
          state_next = lpfs_pkg::ST_STORE;
        end
      end
      lpfs_pkg::ST_STORE: begin
        cmd.step_write = 1'b1;
        if (chan == lpfs_pkg::CH_BLUE) begin
          chan_next  = lpfs_pkg::CH_RED;
          state_next = lpfs_pkg::ST_FINISH;
        end else begin
          chan_next  = chan + 1'b1;
          state_next = lpfs_pkg::ST_LOAD;
        end
      end
      lpfs_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = lpfs_pkg::ST_IDLE;
        end
      end
      default: state_next = lpfs_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_adv_path: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && !tick_stall && status.advance) |=> state == lpfs_pkg::ST_RD_CUR)
    else $error("advance tick did not start palette reads");

  a_hold_path: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && !tick_stall && !status.advance) |=> state == lpfs_pkg::ST_FINISH)
    else $error("plain tick did not go straight to commit");

  a_bitcnt: assert property (@(posedge clk) disable iff (rst)
    (state != lpfs_pkg::ST_DIVIDE) |-> (bit_cnt == '0))
    else $error("divide counter left nonzero outside divide");

  a_chan: assert property (@(posedge clk) disable iff (rst)
    (state == lpfs_pkg::ST_FINISH) |-> (chan == lpfs_pkg::CH_RED))
    else $error("channel counter not rewound at commit");
`endif

endmodule

### hdl/lpfs_dp.sv
// Fade state, shared serial step divider and result register.
module lpfs_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [3:0]                    pressed_quadrants,
  input  lpfs_pkg::cmd_t                cmd,
  output lpfs_pkg::status_t             status,
  input  logic [lpfs_pkg::COUNT_W-1:0]  color_count,
  input  logic [lpfs_pkg::TICK_W-1:0]   steps_per_color,
  output logic                          rd_en,
  output logic [lpfs_pkg::IDX_W-1:0]    rd_addr,
  input  logic [lpfs_pkg::RGB_W-1:0]    rd_data,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [7:0]                    q0_red,
  output logic [7:0]                    q0_green,
  output logic [7:0]                    q0_blue,
  output logic [7:0]                    q1_red,
  output logic [7:0]                    q1_green,
  output logic [7:0]                    q1_blue,
  output logic [7:0]                    q2_red,
  output logic [7:0]                    q2_green,
  output logic [7:0]                    q2_blue,
  output logic [7:0]                    q3_red,
  output logic [7:0]                    q3_green,
  output logic [7:0]                    q3_blue
);

  localparam int CW = lpfs_pkg::CHAN_W;
  localparam int SW = lpfs_pkg::STEP_W;
  localparam int TW = lpfs_pkg::TICK_W;
  localparam int IW = lpfs_pkg::IDX_W;

  logic [3:0]                  pressed;
  logic [CW-1:0]               fade_red, fade_green, fade_blue;
  logic [SW-1:0]               red_step, green_step, blue_step;
  logic [IW-1:0]               palette_index;
  logic [TW-1:0]               tick_count;
  logic [lpfs_pkg::RGB_W-1:0]  from_rgb;
  logic [TW-1:0]               rem;
  logic [CW-1:0]               dq;
  logic                        neg;
  logic [3:0]                  out_pressed;
  logic [CW-1:0]               out_red, out_green, out_blue;

  logic [TW-1:0]                   eff_steps;
  logic [lpfs_pkg::COUNT_W-1:0]    eff_count;
  logic [TW:0]                     tick_inc;
  logic [IW:0]                     idx_inc;
  logic [IW-1:0]                   nxt_idx;
  logic [IW-1:0]                   cur_idx;
  logic [CW-1:0]                   from_c, to_c, mag;
  logic [CW:0]                     diff, neg_diff, quot, step_val;
  logic [TW:0]                     trial, trial_sub;
  logic                            ge;

  function automatic logic [7:0] shade(input logic p, input logic [7:0] c);
    return p ? ((~c) - lpfs_pkg::INVERT_OFFSET) : c;
  endfunction

  always_comb begin
    eff_steps = (steps_per_color == '0) ? TW'(1) : steps_per_color;
    if (color_count == '0) begin
      eff_count = lpfs_pkg::COUNT_W'(1);
    end else if (color_count > lpfs_pkg::COUNT_W'(lpfs_pkg::PALETTE_SIZE)) begin
      eff_count = lpfs_pkg::COUNT_W'(lpfs_pkg::PALETTE_SIZE);
    end else begin
      eff_count = color_count;
    end
    tick_inc = {1'b0, tick_count} + 1'b1;
    idx_inc  = {1'b0, palette_index} + 1'b1;
    nxt_idx  = (idx_inc >= {1'b0, eff_count}) ? '0 : idx_inc[IW-1:0];
    cur_idx  = (palette_index < IW'(lpfs_pkg::PALETTE_SIZE)) ? palette_index : '0;
    status.advance  = (tick_inc >= {1'b0, eff_steps});
    status.out_free = ~result_valid | ~result_stall;
    rd_en   = cmd.rd_en;
    rd_addr = cmd.rd_next ? nxt_idx : cur_idx;

    case (cmd.chan)
      lpfs_pkg::CH_RED: begin
        from_c = from_rgb[23:16];
        to_c   = rd_data[23:16];
      end
      lpfs_pkg::CH_GREEN: begin
        from_c = from_rgb[15:8];
        to_c   = rd_data[15:8];
      end
      default: begin
        from_c = from_rgb[7:0];
        to_c   = rd_data[7:0];
      end
    endcase
    diff     = {1'b0, to_c} - {1'b0, from_c};
    neg_diff = '0 - diff;
    mag      = diff[CW] ? neg_diff[CW-1:0] : diff[CW-1:0];

    trial     = {rem, dq[CW-1]};
    trial_sub = trial - {1'b0, eff_steps};
    ge        = (trial >= {1'b0, eff_steps});

    quot     = {1'b0, dq};
    step_val = neg ? ('0 - quot) : quot;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pressed <= pressed_quadrants;
    end
    if (cmd.from_load) begin
      from_rgb <= rd_data;
    end
    if (cmd.div_load) begin
      rem <= '0;
      dq  <= mag;
      neg <= diff[CW];
    end else if (cmd.div_iter) begin
      rem <= ge ? trial_sub[TW-1:0] : trial[TW-1:0];
      dq  <= {dq[CW-2:0], ge};
    end
    if (cmd.commit) begin
      out_pressed <= pressed;
      out_red     <= fade_red;
      out_green   <= fade_green;
      out_blue    <= fade_blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_red      <= '0;
      fade_green    <= '0;
      fade_blue     <= '0;
      red_step      <= lpfs_pkg::RED_STEP_RESET;
      green_step    <= lpfs_pkg::GREEN_STEP_RESET;
      blue_step     <= lpfs_pkg::BLUE_STEP_RESET;
      palette_index <= '0;
      tick_count    <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (cmd.step_write) begin
        case (cmd.chan)
          lpfs_pkg::CH_RED:   red_step   <= step_val;
          lpfs_pkg::CH_GREEN: green_step <= step_val;
          default:            blue_step  <= step_val;
        endcase
      end
      if (cmd.commit) begin
        fade_red   <= fade_red + red_step[CW-1:0];
        fade_green <= fade_green + green_step[CW-1:0];
        fade_blue  <= fade_blue + blue_step[CW-1:0];
        if (status.advance) begin
          palette_index <= nxt_idx;
          tick_count    <= TW'(1);
        end else begin
          tick_count <= tick_inc[TW-1:0];
        end
      end
      if (cmd.commit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign q0_red   = shade(out_pressed[0], out_red);
  assign q0_green = shade(out_pressed[0], out_green);
  assign q0_blue  = shade(out_pressed[0], out_blue);
  assign q1_red   = shade(out_pressed[1], out_red);
  assign q1_green = shade(out_pressed[1], out_green);
  assign q1_blue  = shade(out_pressed[1], out_blue);
  assign q2_red   = shade(out_pressed[2], out_red);
  assign q2_green = shade(out_pressed[2], out_green);
  assign q2_blue  = shade(out_pressed[2], out_blue);
  assign q3_red   = shade(out_pressed[3], out_red);
  assign q3_green = shade(out_pressed[3], out_green);
  assign q3_blue  = shade(out_pressed[3], out_blue);

endmodule

### hdl/led_palette_fade_sequencer_core.sv
// Top level of the LED palette fade sequencer: registers, controller, datapath.
//
// Each item on the tick channel (tick_valid / tick_stall) is one update tick
// carrying pressed_quadrants. For every tick one item leaves on the result
// channel (result_valid / result_stall): an RGB color per quadrant, the fade
// color or its inverse (127 - c) for a pressed quadrant, sampled before the
// fade advances. Configuration goes through the APB-style port; write it only
// while no tick is in flight.
// A tick that stays on the current palette entry goes from accept straight to
// the commit state. A tick that moves to the next entry first does two palette
// memory reads, then three passes (red, green, blue) of one shared 8-iteration
// serial divider, each pass loading, iterating and storing one channel step.
// A new tick is accepted once the previous one has committed its result.
// A held result waits in the output register while result_stall is high; the
// next tick is still accepted and processed, and waits to commit until the
// output register is free.
// Reset (rst, synchronous) restores the register defaults, blanks the fade to
// black aimed at palette entry 0 and empties the output register.
module led_palette_fade_sequencer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpfs_pkg::ADDR_W-1:0]   paddr,
  input  logic [lpfs_pkg::DATA_W-1:0]   pwdata,
  output logic [lpfs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          tick_valid,
  output logic                          tick_stall,
  input  logic [3:0]                    pressed_quadrants,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [7:0]                    q0_red,
  output logic [7:0]                    q0_green,
  output logic [7:0]                    q0_blue,
  output logic [7:0]                    q1_red,
  output logic [7:0]                    q1_green,
  output logic [7:0]                    q1_blue,
  output logic [7:0]                    q2_red,
  output logic [7:0]                    q2_green,
  output logic [7:0]                    q2_blue,
  output logic [7:0]                    q3_red,
  output logic [7:0]                    q3_green,
  output logic [7:0]                    q3_blue
);

  lpfs_pkg::cmd_t                   cmd;
  lpfs_pkg::status_t                status;
  logic [lpfs_pkg::COUNT_W-1:0]     color_count;
  logic [lpfs_pkg::TICK_W-1:0]      steps_per_color;
  logic                             rd_en;
  logic [lpfs_pkg::IDX_W-1:0]       rd_addr;
  logic [lpfs_pkg::RGB_W-1:0]       rd_data;

  lpfs_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .color_count     (color_count),
    .steps_per_color (steps_per_color),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data)
  );

  lpfs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .status     (status),
    .cmd        (cmd)
  );

  lpfs_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .pressed_quadrants (pressed_quadrants),
    .cmd               (cmd),
    .status            (status),
    .color_count       (color_count),
    .steps_per_color   (steps_per_color),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .q0_red            (q0_red),
    .q0_green          (q0_green),
    .q0_blue           (q0_blue),
    .q1_red            (q1_red),
    .q1_green          (q1_green),
    .q1_blue           (q1_blue),
    .q2_red            (q2_red),
    .q2_green          (q2_green),
    .q2_blue           (q2_blue),
    .q3_red            (q3_red),
    .q3_green          (q3_green),
    .q3_blue           (q3_blue)
  );

endmodule
